[design/mips_ieu_pkg.sv]
`timescale 1ns / 1ps
package mips_ieu_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [4:0] CP0_MF = 5'h00;
  localparam logic [4:0] CP0_MT = 5'h04;
  localparam logic [4:0] CP0_SR = 5'd12;

  localparam logic [4:0] LINK_REG = 5'd31;
  localparam int unsigned ISO_BIT = 16;

  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_READ  = 2'd1;
  localparam logic [1:0] MOP_WRITE = 2'd2;

  localparam logic [1:0] MSZ_BYTE = 2'd0;
  localparam logic [1:0] MSZ_HALF = 2'd1;
  localparam logic [1:0] MSZ_WORD = 2'd2;

  localparam logic [1:0] EXT_WORD  = 2'd0;
  localparam logic [1:0] EXT_BYTES = 2'd1;
  localparam logic [1:0] EXT_BYTEU = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SYSCALL  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_UNALIGN  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_BADCOP0  = 3'd5;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

  // strip address bits for the two masked regions
  function automatic logic [31:0] region(input logic [31:0] a);
    logic [31:0] r;
    r = a;
    if (a[31:29] == 3'd4) r = a & 32'h7fffffff;
    else if (a[31:29] == 3'd5) r = a & 32'h1fffffff;
    return r;
  endfunction

endpackage

[design/mips_ieu_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle, with the
// divide-by-zero and signed overflow answers settled up front.
module mips_ieu_div (
  input  logic                   clk,
  input  logic                   rst,
  input  mips_ieu_pkg::div_req_t req,
  output mips_ieu_pkg::div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  count;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] den;
  logic        neg_q;
  logic        neg_r;
  logic        fin;
  logic [32:0] trial;
  logic [31:0] num_mag;
  logic [31:0] den_mag;

  assign num_mag = (req.sgn && req.num[31]) ? 32'd0 - req.num : req.num;
  assign den_mag = (req.sgn && req.den[31]) ? 32'd0 - req.den : req.den;
  assign trial   = {rem, quo[31]} - {1'b0, den};

  // start a division or settle its special cases, then iterate the shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        if (req.den == 32'd0) begin
          rem   <= req.num;
          quo   <= (req.sgn && req.num[31]) ? 32'd1 : 32'hffffffff;
          neg_q <= 1'b0;
          neg_r <= 1'b0;
          fin   <= 1'b1;
        end else if (req.sgn && req.num == 32'h80000000 && req.den == 32'hffffffff) begin
          rem   <= 32'd0;
          quo   <= 32'h80000000;
          neg_q <= 1'b0;
          neg_r <= 1'b0;
          fin   <= 1'b1;
        end else begin
          busy  <= 1'b1;
          count <= 6'd32;
          quo   <= num_mag;
          rem   <= 32'd0;
          den   <= den_mag;
          neg_q <= req.sgn && (req.num[31] ^ req.den[31]);
          neg_r <= req.sgn && req.num[31];
        end
      end else if (busy) begin
        if (!trial[32]) rem <= trial[31:0];
        else rem <= {rem[30:0], quo[31]};
        quo   <= {quo[30:0], !trial[32]};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = fin;
  assign rsp.quo  = neg_q ? 32'd0 - quo : quo;
  assign rsp.rem  = neg_r ? 32'd0 - rem : rem;

endmodule

[design/mips_integer_execute_unit.sv]
`timescale 1ns / 1ps
// The register file is read at the accepting edge, then the request is executed and
// written back and its result registered and offered; a new request is accepted only
// once that result is taken (read, execute, hand-off). div and divu also wait for the
// divider (one quotient bit a cycle); divide by zero and the signed overflow case
// skip the bit loop. Output stalls hold the block until the result is taken.
// Reset clears the control state, HI, LO, SR and the register file valid bits.
module mips_integer_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] instr_word,
  input  logic [31:0] cur_pc,
  input  logic [31:0] seq_next_pc,
  input  logic [31:0] ret_data,
  input  logic [4:0]  ret_dest,
  input  logic [1:0]  ret_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] new_next_pc,
  output logic [1:0]  mem_op,
  output logic [1:0]  mem_size,
  output logic [31:0] mem_address,
  output logic [31:0] mem_wdata,
  output logic [4:0]  load_target,
  output logic [1:0]  load_extend,
  output logic [2:0]  status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  // held request
  logic        q_action;
  logic [31:0] q_word;
  logic [31:0] q_pc;
  logic [31:0] q_seq;
  logic [31:0] q_rdata;
  logic [4:0]  q_rdest;
  logic [1:0]  q_rkind;

  // register file: two read ports, one write port, valid bits for reset
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [31:0] rf_valid;
  logic [31:0] rda_raw;
  logic [31:0] rdb_raw;
  logic [4:0]  rda_idx;
  logic [4:0]  rdb_idx;
  logic        we;
  logic [4:0]  wa;
  logic [31:0] wd;

  logic [31:0] hi_reg;
  logic [31:0] lo_reg;
  logic [31:0] status_reg;

  mips_ieu_pkg::div_req_t dreq;
  mips_ieu_pkg::div_rsp_t drsp;

  logic        accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  // read and write the register file
  always_ff @(posedge clk) begin
    if (we) begin
      rf_a[wa] <= wd;
      rf_b[wa] <= wd;
    end
    rda_raw <= rf_a[instr_word[25:21]];
    rdb_raw <= rf_b[instr_word[20:16]];
    rda_idx <= instr_word[25:21];
    rdb_idx <= instr_word[20:16];
  end

  always_ff @(posedge clk) begin
    if (rst) rf_valid <= 32'd0;
    else if (we) rf_valid[wa] <= 1'b1;
  end

  logic [31:0] a;
  logic [31:0] b;
  assign a = (rda_idx != 5'd0 && rf_valid[rda_idx]) ? rda_raw : 32'd0;
  assign b = (rdb_idx != 5'd0 && rf_valid[rdb_idx]) ? rdb_raw : 32'd0;

  // execute
  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] btgt;
  logic [31:0] jtgt;
  logic [31:0] ea;
  logic [31:0] sum;
  logic [31:0] sumi;
  logic        iso;
  logic [31:0] rv;

  logic [31:0] npc;
  logic [1:0]  r_op;
  logic [1:0]  r_size;
  logic [31:0] r_addr;
  logic [31:0] r_wdata;
  logic [4:0]  r_ltgt;
  logic [1:0]  r_lext;
  logic [2:0]  r_st;
  logic        w_en;
  logic [4:0]  w_idx;
  logic [31:0] w_val;
  logic        hi_we;
  logic        lo_we;
  logic        sr_we;
  logic        div_go;
  logic        div_sgn;

  assign opc  = q_word[31:26];
  assign fn   = q_word[5:0];
  assign rs   = q_word[25:21];
  assign rt   = q_word[20:16];
  assign rd   = q_word[15:11];
  assign sh   = q_word[10:6];
  assign imm  = {16'd0, q_word[15:0]};
  assign simm = {{16{q_word[15]}}, q_word[15:0]};
  assign btgt = q_pc + {simm[29:0], 2'b00};
  assign jtgt = {q_pc[31:28], q_word[25:0], 2'b00};
  assign ea   = a + simm;
  assign sum  = a + b;
  assign sumi = a + simm;
  assign iso  = status_reg[mips_ieu_pkg::ISO_BIT];

  always_comb begin
    npc = q_seq;
    r_op = mips_ieu_pkg::MOP_NONE;
    r_size = mips_ieu_pkg::MSZ_BYTE;
    r_addr = 32'd0;
    r_wdata = 32'd0;
    r_ltgt = 5'd0;
    r_lext = mips_ieu_pkg::EXT_WORD;
    r_st = mips_ieu_pkg::ST_OK;
    w_en = 1'b0;
    w_idx = rt;
    w_val = 32'd0;
    hi_we = 1'b0;
    lo_we = 1'b0;
    sr_we = 1'b0;
    div_go = 1'b0;
    div_sgn = 1'b0;
    rv = q_rdata;
    if (q_action) begin
      case (q_rkind)
        mips_ieu_pkg::EXT_BYTES: rv = {{24{q_rdata[7]}}, q_rdata[7:0]};
        mips_ieu_pkg::EXT_BYTEU: rv = {24'd0, q_rdata[7:0]};
        default: rv = q_rdata;
      endcase
      w_en = 1'b1;
      w_idx = q_rdest;
      w_val = rv;
    end else begin
      case (opc)
        mips_ieu_pkg::OP_SPECIAL: begin
          w_idx = rd;
          case (fn)
            mips_ieu_pkg::FN_SLL: begin w_en = 1'b1; w_val = b << sh; end
            mips_ieu_pkg::FN_SRL: begin w_en = 1'b1; w_val = b >> sh; end
            mips_ieu_pkg::FN_SRA: begin
              w_en = 1'b1;
              w_val = 32'($signed(b) >>> sh);
            end
            mips_ieu_pkg::FN_JR: npc = a;
            mips_ieu_pkg::FN_JALR: begin npc = a; w_en = 1'b1; w_val = q_seq; end
            mips_ieu_pkg::FN_SYSCALL: r_st = mips_ieu_pkg::ST_SYSCALL;
            mips_ieu_pkg::FN_MFHI: begin w_en = 1'b1; w_val = hi_reg; end
            mips_ieu_pkg::FN_MTHI: hi_we = 1'b1;
            mips_ieu_pkg::FN_MFLO: begin w_en = 1'b1; w_val = lo_reg; end
            mips_ieu_pkg::FN_MTLO: lo_we = 1'b1;
            mips_ieu_pkg::FN_DIV: begin div_go = 1'b1; div_sgn = 1'b1; end
            mips_ieu_pkg::FN_DIVU: div_go = 1'b1;
            mips_ieu_pkg::FN_ADD: begin
              if (!(a[31] ^ b[31]) && (a[31] ^ sum[31]))
                r_st = mips_ieu_pkg::ST_OVERFLOW;
              else begin
                w_en = 1'b1;
                w_val = sum;
              end
            end
            mips_ieu_pkg::FN_ADDU: begin w_en = 1'b1; w_val = sum; end
            mips_ieu_pkg::FN_SUBU: begin w_en = 1'b1; w_val = a - b; end
            mips_ieu_pkg::FN_AND: begin w_en = 1'b1; w_val = a & b; end
            mips_ieu_pkg::FN_OR: begin w_en = 1'b1; w_val = a | b; end
            mips_ieu_pkg::FN_SLT: begin
              w_en = 1'b1;
              w_val = {31'd0, $signed(a) < $signed(b)};
            end
            mips_ieu_pkg::FN_SLTU: begin w_en = 1'b1; w_val = {31'd0, a < b}; end
            default: r_st = mips_ieu_pkg::ST_UNKNOWN;
          endcase
        end
        mips_ieu_pkg::OP_REGIMM: begin
          if (q_word[20:17] == 4'd8) begin
            w_en = 1'b1;
            w_idx = mips_ieu_pkg::LINK_REG;
            w_val = q_seq;
          end
          if (a[31] ^ q_word[16]) npc = btgt;
        end
        mips_ieu_pkg::OP_JAL: begin
          w_en = 1'b1;
          w_idx = mips_ieu_pkg::LINK_REG;
          w_val = q_seq;
          npc = jtgt;
        end
        mips_ieu_pkg::OP_J: npc = jtgt;
        mips_ieu_pkg::OP_BEQ: if (a == b) npc = btgt;
        mips_ieu_pkg::OP_BNE: if (a != b) npc = btgt;
        mips_ieu_pkg::OP_BLEZ: if (a[31] || a == 32'd0) npc = btgt;
        mips_ieu_pkg::OP_BGTZ: if (!a[31] && a != 32'd0) npc = btgt;
        mips_ieu_pkg::OP_ADDI: begin
          if (!(a[31] ^ simm[31]) && (a[31] ^ sumi[31]))
            r_st = mips_ieu_pkg::ST_OVERFLOW;
          else begin
            w_en = 1'b1;
            w_val = sumi;
          end
        end
        mips_ieu_pkg::OP_ADDIU: begin w_en = 1'b1; w_val = sumi; end
        mips_ieu_pkg::OP_SLTI: begin
          w_en = 1'b1;
          w_val = {31'd0, $signed(a) < $signed(simm)};
        end
        mips_ieu_pkg::OP_SLTIU: begin w_en = 1'b1; w_val = {31'd0, a < simm}; end
        mips_ieu_pkg::OP_ANDI: begin w_en = 1'b1; w_val = a & imm; end
        mips_ieu_pkg::OP_ORI: begin w_en = 1'b1; w_val = a | imm; end
        mips_ieu_pkg::OP_LUI: begin w_en = 1'b1; w_val = {q_word[15:0], 16'd0}; end
        mips_ieu_pkg::OP_COP0: begin
          case (rs)
            mips_ieu_pkg::CP0_MF: begin
              if (rd != mips_ieu_pkg::CP0_SR) r_st = mips_ieu_pkg::ST_UNKNOWN;
              else begin
                w_en = 1'b1;
                w_val = status_reg;
              end
            end
            mips_ieu_pkg::CP0_MT: begin
              if (rd == mips_ieu_pkg::CP0_SR) sr_we = 1'b1;
              else if (rd inside {5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13}) begin
                if (b != 32'd0) r_st = mips_ieu_pkg::ST_BADCOP0;
              end else r_st = mips_ieu_pkg::ST_BADCOP0;
            end
            default: r_st = mips_ieu_pkg::ST_UNKNOWN;
          endcase
        end
        mips_ieu_pkg::OP_LB, mips_ieu_pkg::OP_LBU: begin
          r_op = mips_ieu_pkg::MOP_READ;
          r_addr = mips_ieu_pkg::region(ea);
          r_ltgt = rt;
          r_lext = (opc == mips_ieu_pkg::OP_LB) ? mips_ieu_pkg::EXT_BYTES
                                                : mips_ieu_pkg::EXT_BYTEU;
        end
        mips_ieu_pkg::OP_LW: begin
          if (!iso) begin
            if (ea[1:0] != 2'd0) r_st = mips_ieu_pkg::ST_UNALIGN;
            else begin
              r_op = mips_ieu_pkg::MOP_READ;
              r_size = mips_ieu_pkg::MSZ_WORD;
              r_addr = mips_ieu_pkg::region(ea);
              r_ltgt = rt;
            end
          end
        end
        mips_ieu_pkg::OP_SB: begin
          if (!iso) begin
            r_op = mips_ieu_pkg::MOP_WRITE;
            r_addr = mips_ieu_pkg::region(ea);
            r_wdata = {24'd0, b[7:0]};
          end
        end
        mips_ieu_pkg::OP_SH: begin
          if (!iso) begin
            if (ea[0]) r_st = mips_ieu_pkg::ST_UNALIGN;
            else begin
              r_op = mips_ieu_pkg::MOP_WRITE;
              r_size = mips_ieu_pkg::MSZ_HALF;
              r_addr = mips_ieu_pkg::region(ea);
              r_wdata = {16'd0, b[15:0]};
            end
          end
        end
        mips_ieu_pkg::OP_SW: begin
          if (!iso) begin
            if (ea[1:0] != 2'd0) r_st = mips_ieu_pkg::ST_UNALIGN;
            else begin
              r_op = mips_ieu_pkg::MOP_WRITE;
              r_size = mips_ieu_pkg::MSZ_WORD;
              r_addr = mips_ieu_pkg::region(ea);
              r_wdata = b;
            end
          end
        end
        default: r_st = mips_ieu_pkg::ST_UNKNOWN;
      endcase
    end
  end

  assign we = (state == S_EXEC) && w_en && (w_idx != 5'd0);
  assign wa = w_idx;
  assign wd = w_val;

  assign dreq.start = (state == S_EXEC) && div_go;
  assign dreq.sgn   = div_sgn;
  assign dreq.num   = a;
  assign dreq.den   = b;

  mips_ieu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // sequence the request and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      hi_reg     <= 32'd0;
      lo_reg     <= 32'd0;
      status_reg <= 32'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            q_action <= action;
            q_word   <= instr_word;
            q_pc     <= cur_pc;
            q_seq    <= seq_next_pc;
            q_rdata  <= ret_data;
            q_rdest  <= ret_dest;
            q_rkind  <= ret_kind;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          new_next_pc <= npc;
          mem_op      <= r_op;
          mem_size    <= r_size;
          mem_address <= r_addr;
          mem_wdata   <= r_wdata;
          load_target <= r_ltgt;
          load_extend <= r_lext;
          status      <= r_st;
          if (hi_we) hi_reg <= a;
          if (lo_we) lo_reg <= a;
          if (sr_we) status_reg <= b;
          if (div_go) state <= S_DIV;
          else begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            hi_reg    <= drsp.rem;
            lo_reg    <= drsp.quo;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while a result waits");
  a_no_r0: assert property (@(posedge clk) disable iff (rst) we |-> wa != 5'd0)
    else $error("write to register zero");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_DIV)
    else $error("divider finished outside divide wait");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [31:0] npc;
    logic [1:0]  mop;
    logic [1:0]  msz;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [4:0]  ltgt;
    logic [1:0]  lext;
    logic [2:0]  st;
  } exec_res_t;

  // Scoreboard: shadow architectural state and the queue of predicted results
  class ieu_scoreboard;
    logic [31:0] regs[32];
    logic [31:0] hi, lo, sr;
    exec_res_t   pending[$];
    int          errors;
    int          checked;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      hi = '0;
      lo = '0;
      sr = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void wr(logic [4:0] i, logic [31:0] v);
      if (i != 5'd0) regs[i] = v;
    endfunction

    function logic ovf(logic [31:0] a, logic [31:0] b, logic [31:0] r);
      logic [31:0] x;
      x = ~(a ^ b) & (a ^ r);
      return x[31];
    endfunction

    function void sdiv(logic [31:0] n, logic [31:0] d);
      logic [31:0] mn, md, q, r;
      if (d == 0) begin
        hi = n;
        lo = n[31] ? 32'd1 : 32'hffffffff;
      end else if (n == 32'h80000000 && d == 32'hffffffff) begin
        hi = 0;
        lo = 32'h80000000;
      end else begin
        mn = n[31] ? -n : n;
        md = d[31] ? -d : d;
        q = mn / md;
        r = mn % md;
        lo = (n[31] != d[31]) ? -q : q;
        hi = n[31] ? -r : r;
      end
    endfunction

    // Predict the result of one accepted request and update the shadow state
    function void note_request(logic act, logic [31:0] w, logic [31:0] pc,
                               logic [31:0] seq, logic [31:0] rdat,
                               logic [4:0] rdst, logic [1:0] rkind);
      exec_res_t   e;
      logic [4:0]  s, t, d, sh;
      logic [31:0] a, b, simm, imm, btgt, ea, r, v;
      logic        iso;
      e = '0;
      e.npc = seq;
      e.st = mips_ieu_pkg::ST_OK;
      if (act) begin
        v = rdat;
        if (rkind == mips_ieu_pkg::EXT_BYTES) v = {{24{rdat[7]}}, rdat[7:0]};
        else if (rkind == mips_ieu_pkg::EXT_BYTEU) v = {24'd0, rdat[7:0]};
        wr(rdst, v);
      end else begin
        s = w[25:21];
        t = w[20:16];
        d = w[15:11];
        sh = w[10:6];
        imm = {16'd0, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        a = regs[s];
        b = regs[t];
        btgt = pc + (simm << 2);
        ea = a + simm;
        iso = sr[mips_ieu_pkg::ISO_BIT];
        case (w[31:26])
          mips_ieu_pkg::OP_SPECIAL: begin
            case (w[5:0])
              mips_ieu_pkg::FN_SLL: wr(d, b << sh);
              mips_ieu_pkg::FN_SRL: wr(d, b >> sh);
              mips_ieu_pkg::FN_SRA: wr(d, $unsigned($signed(b) >>> sh));
              mips_ieu_pkg::FN_JR: e.npc = a;
              mips_ieu_pkg::FN_JALR: begin
                wr(d, seq);
                e.npc = a;
              end
              mips_ieu_pkg::FN_SYSCALL: e.st = mips_ieu_pkg::ST_SYSCALL;
              mips_ieu_pkg::FN_MFHI: wr(d, hi);
              mips_ieu_pkg::FN_MTHI: hi = a;
              mips_ieu_pkg::FN_MFLO: wr(d, lo);
              mips_ieu_pkg::FN_MTLO: lo = a;
              mips_ieu_pkg::FN_DIV: sdiv(a, b);
              mips_ieu_pkg::FN_DIVU: begin
                if (b == 0) begin
                  hi = a;
                  lo = 32'hffffffff;
                end else begin
                  hi = a % b;
                  lo = a / b;
                end
              end
              mips_ieu_pkg::FN_ADD: begin
                r = a + b;
                if (ovf(a, b, r)) e.st = mips_ieu_pkg::ST_OVERFLOW;
                else wr(d, r);
              end
              mips_ieu_pkg::FN_ADDU: wr(d, a + b);
              mips_ieu_pkg::FN_SUBU: wr(d, a - b);
              mips_ieu_pkg::FN_AND: wr(d, a & b);
              mips_ieu_pkg::FN_OR: wr(d, a | b);
              mips_ieu_pkg::FN_SLT: wr(d, {31'd0, $signed(a) < $signed(b)});
              mips_ieu_pkg::FN_SLTU: wr(d, {31'd0, a < b});
              default: e.st = mips_ieu_pkg::ST_UNKNOWN;
            endcase
          end
          mips_ieu_pkg::OP_REGIMM: begin
            if (w[20:17] == 4'd8) wr(mips_ieu_pkg::LINK_REG, seq);
            if (a[31] ^ w[16]) e.npc = btgt;
          end
          mips_ieu_pkg::OP_JAL: begin
            wr(mips_ieu_pkg::LINK_REG, seq);
            e.npc = {pc[31:28], w[25:0], 2'b00};
          end
          mips_ieu_pkg::OP_J: e.npc = {pc[31:28], w[25:0], 2'b00};
          mips_ieu_pkg::OP_BEQ: if (a == b) e.npc = btgt;
          mips_ieu_pkg::OP_BNE: if (a != b) e.npc = btgt;
          mips_ieu_pkg::OP_BLEZ: if (a[31] || a == 0) e.npc = btgt;
          mips_ieu_pkg::OP_BGTZ: if (!a[31] && a != 0) e.npc = btgt;
          mips_ieu_pkg::OP_ADDI: begin
            r = a + simm;
            if (ovf(a, simm, r)) e.st = mips_ieu_pkg::ST_OVERFLOW;
            else wr(t, r);
          end
          mips_ieu_pkg::OP_ADDIU: wr(t, a + simm);
          mips_ieu_pkg::OP_SLTI: wr(t, {31'd0, $signed(a) < $signed(simm)});
          mips_ieu_pkg::OP_SLTIU: wr(t, {31'd0, a < simm});
          mips_ieu_pkg::OP_ANDI: wr(t, a & imm);
          mips_ieu_pkg::OP_ORI: wr(t, a | imm);
          mips_ieu_pkg::OP_LUI: wr(t, imm << 16);
          mips_ieu_pkg::OP_COP0: begin
            if (s == mips_ieu_pkg::CP0_MF) begin
              if (d != mips_ieu_pkg::CP0_SR) e.st = mips_ieu_pkg::ST_UNKNOWN;
              else wr(t, sr);
            end else if (s == mips_ieu_pkg::CP0_MT) begin
              if (d == mips_ieu_pkg::CP0_SR) sr = b;
              else if (d inside {5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13}) begin
                if (b != 0) e.st = mips_ieu_pkg::ST_BADCOP0;
              end else e.st = mips_ieu_pkg::ST_BADCOP0;
            end else e.st = mips_ieu_pkg::ST_UNKNOWN;
          end
          mips_ieu_pkg::OP_LB, mips_ieu_pkg::OP_LBU: begin
            e.mop = mips_ieu_pkg::MOP_READ;
            e.msz = mips_ieu_pkg::MSZ_BYTE;
            e.addr = mips_ieu_pkg::region(ea);
            e.ltgt = t;
            e.lext = (w[31:26] == mips_ieu_pkg::OP_LB) ? mips_ieu_pkg::EXT_BYTES
                                                       : mips_ieu_pkg::EXT_BYTEU;
          end
          mips_ieu_pkg::OP_LW: if (!iso) begin
            if (ea[1:0] != 0) e.st = mips_ieu_pkg::ST_UNALIGN;
            else begin
              e.mop = mips_ieu_pkg::MOP_READ;
              e.msz = mips_ieu_pkg::MSZ_WORD;
              e.addr = mips_ieu_pkg::region(ea);
              e.ltgt = t;
            end
          end
          mips_ieu_pkg::OP_SB: if (!iso) begin
            e.mop = mips_ieu_pkg::MOP_WRITE;
            e.msz = mips_ieu_pkg::MSZ_BYTE;
            e.addr = mips_ieu_pkg::region(ea);
            e.wdata = b & 32'hff;
          end
          mips_ieu_pkg::OP_SH: if (!iso) begin
            if (ea[0]) e.st = mips_ieu_pkg::ST_UNALIGN;
            else begin
              e.mop = mips_ieu_pkg::MOP_WRITE;
              e.msz = mips_ieu_pkg::MSZ_HALF;
              e.addr = mips_ieu_pkg::region(ea);
              e.wdata = b & 32'hffff;
            end
          end
          mips_ieu_pkg::OP_SW: if (!iso) begin
            if (ea[1:0] != 0) e.st = mips_ieu_pkg::ST_UNALIGN;
            else begin
              e.mop = mips_ieu_pkg::MOP_WRITE;
              e.msz = mips_ieu_pkg::MSZ_WORD;
              e.addr = mips_ieu_pkg::region(ea);
              e.wdata = b;
            end
          end
          default: e.st = mips_ieu_pkg::ST_UNKNOWN;
        endcase
      end
      pending.push_back(e);
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.npc !== e.npc) begin
        $error("new_next_pc exp %h got %h", e.npc, got.npc); errors++;
      end
      if (got.mop !== e.mop) begin
        $error("mem_op exp %0d got %0d", e.mop, got.mop); errors++;
      end
      if (got.msz !== e.msz) begin
        $error("mem_size exp %0d got %0d", e.msz, got.msz); errors++;
      end
      if (got.addr !== e.addr) begin
        $error("mem_address exp %h got %h", e.addr, got.addr); errors++;
      end
      if (got.wdata !== e.wdata) begin
        $error("mem_wdata exp %h got %h", e.wdata, got.wdata); errors++;
      end
      if (got.ltgt !== e.ltgt) begin
        $error("load_target exp %0d got %0d", e.ltgt, got.ltgt); errors++;
      end
      if (got.lext !== e.lext) begin
        $error("load_extend exp %0d got %0d", e.lext, got.lext); errors++;
      end
      if (got.st !== e.st) begin
        $error("status exp %0d got %0d", e.st, got.st); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [31:0] instr_word = '0;
  logic [31:0] cur_pc = '0;
  logic [31:0] seq_next_pc = '0;
  logic [31:0] ret_data = '0;
  logic [4:0]  ret_dest = '0;
  logic [1:0]  ret_kind = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] new_next_pc;
  logic [1:0]  mem_op;
  logic [1:0]  mem_size;
  logic [31:0] mem_address;
  logic [31:0] mem_wdata;
  logic [4:0]  load_target;
  logic [1:0]  load_extend;
  logic [2:0]  status;

  mips_integer_execute_unit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ieu_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  n_exec = 0;
  int  n_wb = 0;

  // Sample results at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({new_next_pc, mem_op, mem_size, mem_address, mem_wdata,
                       load_target, load_extend, status});
  end

  // Drive out_ready at the falling edge; a hold-off keeps it low for a stretch
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request and hold it until accepted; valid drops only while idling
  task automatic send_request(logic act, logic [31:0] w, logic [31:0] rdat,
                              logic [4:0] rdst, logic [1:0] rkind);
    logic [31:0] pc;
    pc = $urandom();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= act;
    instr_word <= w;
    cur_pc <= pc;
    seq_next_pc <= pc + 4;
    ret_data <= rdat;
    ret_dest <= rdst;
    ret_kind <= rkind;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(act, w, pc, pc + 4, rdat, rdst, rkind);
    if (act) n_wb++;
    else n_exec++;
    @(negedge clk);
  endtask

  task automatic exec(logic [31:0] w);
    send_request(1'b0, w, $urandom(), 5'($urandom()), 2'($urandom()));
  endtask

  task automatic load_back(logic [4:0] r, logic [31:0] v, logic [1:0] k);
    send_request(1'b1, $urandom(), v, r, k);
  endtask

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] s, logic [4:0] t,
                                        logic [15:0] imm);
    return {op, s, t, imm};
  endfunction

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] s, logic [4:0] t,
                                        logic [4:0] d, logic [4:0] sh);
    return {mips_ieu_pkg::OP_SPECIAL, s, t, d, sh, fn};
  endfunction

  // Build a random instruction biased towards the listed operations
  function automatic logic [31:0] rand_instr();
    logic [5:0]  ops[22];
    logic [5:0]  fns[19];
    logic [31:0] w;
    logic [4:0]  s, t, d;
    int          k;
    ops = '{mips_ieu_pkg::OP_SPECIAL, mips_ieu_pkg::OP_REGIMM, mips_ieu_pkg::OP_J,
            mips_ieu_pkg::OP_JAL, mips_ieu_pkg::OP_BEQ, mips_ieu_pkg::OP_BNE,
            mips_ieu_pkg::OP_BLEZ, mips_ieu_pkg::OP_BGTZ, mips_ieu_pkg::OP_ADDI,
            mips_ieu_pkg::OP_ADDIU, mips_ieu_pkg::OP_SLTI, mips_ieu_pkg::OP_SLTIU,
            mips_ieu_pkg::OP_ANDI, mips_ieu_pkg::OP_ORI, mips_ieu_pkg::OP_LUI,
            mips_ieu_pkg::OP_COP0, mips_ieu_pkg::OP_LB, mips_ieu_pkg::OP_LW,
            mips_ieu_pkg::OP_LBU, mips_ieu_pkg::OP_SB, mips_ieu_pkg::OP_SH,
            mips_ieu_pkg::OP_SW};
    fns = '{mips_ieu_pkg::FN_SLL, mips_ieu_pkg::FN_SRL, mips_ieu_pkg::FN_SRA,
            mips_ieu_pkg::FN_JR, mips_ieu_pkg::FN_JALR, mips_ieu_pkg::FN_SYSCALL,
            mips_ieu_pkg::FN_MFHI, mips_ieu_pkg::FN_MTHI, mips_ieu_pkg::FN_MFLO,
            mips_ieu_pkg::FN_MTLO, mips_ieu_pkg::FN_DIV, mips_ieu_pkg::FN_DIVU,
            mips_ieu_pkg::FN_ADD, mips_ieu_pkg::FN_ADDU, mips_ieu_pkg::FN_SUBU,
            mips_ieu_pkg::FN_AND, mips_ieu_pkg::FN_OR, mips_ieu_pkg::FN_SLT,
            mips_ieu_pkg::FN_SLTU};
    w = $urandom();
    s = 5'($urandom_range(7));
    t = 5'($urandom_range(7));
    d = 5'($urandom_range(7));
    if ($urandom_range(9) == 0) begin
      s = 5'($urandom());
      t = 5'($urandom());
      d = 5'($urandom());
    end
    k = $urandom_range(99);
    if (k < 3) return w;
    if (k < 40) begin
      w[31:26] = mips_ieu_pkg::OP_SPECIAL;
      w[5:0] = fns[$urandom_range(18)];
    end else begin
      w[31:26] = ops[$urandom_range(21)];
    end
    w[25:21] = s;
    w[20:16] = t;
    if (w[31:26] == mips_ieu_pkg::OP_SPECIAL) w[15:11] = d;
    // keep memory offsets mostly aligned so requests get through
    if (w[31:26] inside {mips_ieu_pkg::OP_LW, mips_ieu_pkg::OP_SW} &&
        $urandom_range(3) != 0) w[1:0] = 2'b00;
    if (w[31:26] == mips_ieu_pkg::OP_SH && $urandom_range(3) != 0) w[0] = 1'b0;
    if (w[31:26] == mips_ieu_pkg::OP_COP0) begin
      w[25:21] = ($urandom_range(7) == 0) ? s :
                 (($urandom_range(1) != 0) ? mips_ieu_pkg::CP0_MT : mips_ieu_pkg::CP0_MF);
      if ($urandom_range(2) != 0) w[15:11] = mips_ieu_pkg::CP0_SR;
      else w[15:11] = 5'($urandom());
    end
    return w;
  endfunction

  task automatic directed_part();
    // extremes into registers through load write-back
    load_back(5'd1, 32'h7fffffff, mips_ieu_pkg::EXT_WORD);
    load_back(5'd2, 32'h80000000, 2'd3);
    load_back(5'd3, 32'hffffffff, mips_ieu_pkg::EXT_WORD);
    load_back(5'd4, 32'h00000080, mips_ieu_pkg::EXT_BYTES);
    load_back(5'd5, 32'hffffff7f, mips_ieu_pkg::EXT_BYTEU);
    load_back(5'd0, 32'hdeadbeef, mips_ieu_pkg::EXT_WORD);
    exec(rtype(mips_ieu_pkg::FN_ADD, 5'd1, 5'd1, 5'd6, 5'd0));
    exec(itype(mips_ieu_pkg::OP_ADDI, 5'd2, 5'd7, 16'h8000));
    exec(rtype(mips_ieu_pkg::FN_DIV, 5'd2, 5'd3, 5'd0, 5'd0));
    exec(rtype(mips_ieu_pkg::FN_MFLO, 5'd0, 5'd0, 5'd8, 5'd0));
    exec(rtype(mips_ieu_pkg::FN_DIV, 5'd2, 5'd0, 5'd0, 5'd0));
    exec(rtype(mips_ieu_pkg::FN_MFHI, 5'd0, 5'd0, 5'd9, 5'd0));
    exec(rtype(mips_ieu_pkg::FN_DIVU, 5'd1, 5'd0, 5'd0, 5'd0));
    exec(rtype(mips_ieu_pkg::FN_MFLO, 5'd0, 5'd0, 5'd10, 5'd0));
    exec(rtype(mips_ieu_pkg::FN_JALR, 5'd31, 5'd0, 5'd31, 5'd0));
    exec(itype(mips_ieu_pkg::OP_REGIMM, 5'd1, 5'h10, 16'h0004));
    exec(itype(mips_ieu_pkg::OP_REGIMM, 5'd2, 5'h11, 16'hfffc));
    exec(rtype(mips_ieu_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
    exec(itype(mips_ieu_pkg::OP_SW, 5'd2, 5'd3, 16'h0002));
    exec(itype(mips_ieu_pkg::OP_SW, 5'd2, 5'd3, 16'h0000));
    exec({mips_ieu_pkg::OP_COP0, mips_ieu_pkg::CP0_MT, 5'd0, 5'd3, 11'd0});
    exec({mips_ieu_pkg::OP_COP0, mips_ieu_pkg::CP0_MT, 5'd1, 5'd3, 11'd0});
    // isolate the cache, try an affected and an unaffected load, then release
    exec(itype(mips_ieu_pkg::OP_LUI, 5'd0, 5'd11, 16'h0001));
    exec({mips_ieu_pkg::OP_COP0, mips_ieu_pkg::CP0_MT, 5'd11, mips_ieu_pkg::CP0_SR, 11'd0});
    exec(itype(mips_ieu_pkg::OP_LW, 5'd0, 5'd12, 16'h0001));
    exec(itype(mips_ieu_pkg::OP_LB, 5'd3, 5'd12, 16'h0000));
    exec({mips_ieu_pkg::OP_COP0, mips_ieu_pkg::CP0_MF, 5'd13, mips_ieu_pkg::CP0_SR, 11'd0});
    exec({mips_ieu_pkg::OP_COP0, mips_ieu_pkg::CP0_MT, 5'd0, mips_ieu_pkg::CP0_SR, 11'd0});
    exec(32'hfc000000);
  endtask

  // Random part: mostly executes, with write-backs of random loads interleaved
  task automatic random_part(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(4) == 0)
        load_back(5'($urandom_range(31)), $urandom(), 2'($urandom_range(3)));
      else
        exec(rand_instr());
    end
  endtask

  initial begin
    sb.clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_part();
    random_part(400);
    send_idle_pct = 78;
    random_part(250);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    random_part(250);
    // long receiver hold-off while requests keep coming
    recv_stall_pct = 0;
    hold_off = 300;
    random_part(100);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_part(300);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_part(200);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d instructions and %0d load write-backs, %0d results checked.",
             n_exec, n_wb, sb.checked);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
